>>> rtl/jsli_pkg.sv
// ----------------------------------------------------------------------------
// jsli_pkg
// Types and constants shared by the joint-space interpolator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jsli_pkg;

  localparam int unsigned NumJoints = 6;
  localparam int unsigned JointW    = 3;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned MagW      = 16;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned SpeedKW   = 25;
  // 1406.25/pi in Q16
  localparam logic [SpeedKW-1:0] SpeedK = 25'd29335439;
  localparam int unsigned ProdW     = MagW + SpeedKW;   // 41
  localparam int unsigned TimeW     = 25;
  localparam int unsigned StepW     = 33;
  localparam int unsigned DvdW      = 34;
  localparam int unsigned DvsW      = 26;
  localparam int unsigned QW        = 17;
  localparam int unsigned AccW      = 27;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_SPEED  = 2'd1,
    REG_PERIOD = 2'd2,
    REG_TTIME  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_TIME  = 2'd0,
    DIV_COUNT = 2'd1,
    DIV_STEP  = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAXD,
    ST_MUL_T,
    ST_GO_T,
    ST_WAIT_T,
    ST_GO_C,
    ST_WAIT_C,
    ST_MUL_S,
    ST_GO_S,
    ST_WAIT_S,
    ST_EMIT,
    ST_SINGLE
  } state_e;

  typedef struct packed {
    logic              capture;
    logic              maxd_step;
    logic              mul_t;
    logic              mul_s;
    logic              div_go;
    div_sel_e          div_sel;
    logic              emit;
    logic              load_single;
    logic [JointW-1:0] joint;
  } cmd_t;

  typedef struct packed {
    logic maxd_zero;
    logic count_zero;
    logic div_done;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/jsli_div.sv
// ----------------------------------------------------------------------------
// jsli_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jsli_div
  import jsli_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DvdW-1:0]      quo_o,
  output logic [DvsW-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] LastCnt = CntW'(DvdW - 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvsW-1:0] dvs_q, rem_q;
  logic [DvsW:0]   rem_sh, rem_sub;
  logic            fits;

  // Shift in next dividend bit and try to subtract
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DvdW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], fits};
      rem_q <= fits ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/jsli_datapath.sv
// ----------------------------------------------------------------------------
// jsli_datapath
// Pose registers, move time and step math, per-joint accumulators, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module jsli_datapath
  import jsli_pkg::*;
#(
  parameter int unsigned MaxFrames = 64,
  parameter int unsigned FrmW      = 7
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output status_t                       status_o,
  input  wire logic [CfgW-1:0]          speed_i,
  input  wire logic [CfgW-1:0]          period_i,
  input  wire logic [CfgW-1:0]          ttime_i,
  input  wire logic [NumJoints-1:0][AngleW-1:0] start_i,
  input  wire logic [NumJoints-1:0][AngleW-1:0] end_i,
  input  wire logic                     out_stall_i,
  output logic                          out_valid_o,
  output logic [NumJoints-1:0][AngleW-1:0] angle_o,
  output logic [CfgW-1:0]               frame_time_o,
  output logic                          last_o
);

  logic [NumJoints-1:0][AngleW-1:0] start_q, end_q;
  logic [NumJoints-1:0][MagW-1:0]   mag_q;
  logic [NumJoints-1:0]             neg_q;
  logic [NumJoints-1:0][QW-1:0]     a_q, q_q;
  logic [NumJoints-1:0][DvsW-1:0]   r_q, acc_q;
  logic [MagW-1:0]  maxd_q;
  logic [ProdW-1:0] prod_q;
  logic [StepW-1:0] step_q;
  logic [TimeW-1:0] t_q;
  logic [FrmW-1:0]  count_q, frame_q;
  logic             out_valid_q;
  logic [NumJoints-1:0][AngleW-1:0] angle_q;
  logic [CfgW-1:0]  ftime_q;
  logic             last_q;

  logic [CfgW-1:0]   speed_eff, period_eff;
  logic [AngleW:0]   delta;
  logic [MagW-1:0]   mag;
  logic [DvdW-1:0]   dvd;
  logic [DvsW-1:0]   dvs;
  logic              div_done;
  logic [DvdW-1:0]   quo;
  logic [DvsW-1:0]   rem;
  logic              out_free, last;

  assign speed_eff  = (speed_i == '0) ? CfgW'(1) : speed_i;
  assign period_eff = (period_i == '0) ? CfgW'(1) : period_i;

  // Delta and magnitude of the joint under the sweep
  always_comb begin
    delta = {end_q[cmd_i.joint][AngleW-1], end_q[cmd_i.joint]}
          - {start_q[cmd_i.joint][AngleW-1], start_q[cmd_i.joint]};
    mag   = delta[AngleW] ? MagW'(-delta) : delta[MagW-1:0];
  end

  // Divider operand select
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_TIME: begin
        dvd = DvdW'(prod_q[ProdW-1:16]);
        dvs = DvsW'(speed_eff);
      end
      DIV_COUNT: begin
        dvd = DvdW'(t_q);
        dvs = DvsW'(period_eff);
      end
      default: begin
        dvd = DvdW'(step_q);
        dvs = {t_q, 1'b0};
      end
    endcase
  end

  jsli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // Capture poses, sweep joint deltas, form products
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      start_q <= start_i;
      end_q   <= end_i;
      maxd_q  <= '0;
    end
    if (cmd_i.maxd_step) begin
      mag_q[cmd_i.joint] <= mag;
      neg_q[cmd_i.joint] <= delta[AngleW];
      if (mag > maxd_q) maxd_q <= mag;
    end
    if (cmd_i.mul_t) prod_q <= maxd_q * SpeedK;
    if (cmd_i.mul_s) step_q <= {32'(period_eff) * 32'(mag_q[cmd_i.joint]), 1'b0};
    if (div_done) begin
      unique case (cmd_i.div_sel)
        DIV_TIME:  t_q <= quo[TimeW-1:0];
        DIV_COUNT: count_q <= (quo > DvdW'(MaxFrames)) ? FrmW'(MaxFrames) : quo[FrmW-1:0];
        default: begin
          a_q[cmd_i.joint]   <= quo[QW-1:0];
          r_q[cmd_i.joint]   <= rem;
          q_q[cmd_i.joint]   <= '0;
          acc_q[cmd_i.joint] <= DvsW'(t_q);
        end
      endcase
    end
    // Advance every joint by one frame step
    if (cmd_i.emit) begin
      for (int k = 0; k < NumJoints; k++) begin
        logic [AccW-1:0] sum;
        sum = AccW'(acc_q[k]) + AccW'(r_q[k]);
        if (sum >= AccW'({t_q, 1'b0})) begin
          acc_q[k] <= DvsW'(sum - AccW'({t_q, 1'b0}));
          q_q[k]   <= q_q[k] + a_q[k] + 1'b1;
        end else begin
          acc_q[k] <= sum[DvsW-1:0];
          q_q[k]   <= q_q[k] + a_q[k];
        end
      end
    end
  end

  // Frame counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (cmd_i.capture) begin
      frame_q <= '0;
    end else if (cmd_i.emit) begin
      frame_q <= frame_q + 1'b1;
    end
  end

  assign last     = (frame_q + 1'b1) == count_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // Output register: hold until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.load_single) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single) begin
      angle_q <= end_q;
      ftime_q <= ttime_i;
      last_q  <= 1'b1;
    end else if (cmd_i.emit) begin
      for (int k = 0; k < NumJoints; k++) begin
        logic [AngleW+1:0] off, s;
        off = neg_q[k] ? -{1'b0, q_q[k]} : {1'b0, q_q[k]};
        s   = {{2{start_q[k][AngleW-1]}}, start_q[k]} + off;
        angle_q[k] <= s[AngleW-1:0];
      end
      ftime_q <= period_i;
      last_q  <= last;
    end
  end

  assign status_o = '{
    maxd_zero:  (maxd_q == '0),
    count_zero: (count_q == '0),
    div_done:   div_done,
    last:       last,
    out_free:   out_free
  };

  assign out_valid_o  = out_valid_q;
  assign angle_o      = angle_q;
  assign frame_time_o = ftime_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

>>> rtl/jsli_ctrl.sv
// ----------------------------------------------------------------------------
// jsli_ctrl
// Sequencer for the interpolator: sweep, divisions, setup, frame emission.
// ----------------------------------------------------------------------------
`default_nettype none

module jsli_ctrl
  import jsli_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire logic    multi_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [JointW-1:0] LastJoint = JointW'(NumJoints - 1);

  state_e            state_q, state_d;
  logic [JointW-1:0] joint_q, joint_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      joint_q <= '0;
    end else begin
      state_q <= state_d;
      joint_q <= joint_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    joint_d = joint_q;
    unique case (state_q)
      ST_IDLE: begin
        joint_d = '0;
        if (in_valid_i) state_d = multi_i ? ST_MAXD : ST_SINGLE;
      end
      ST_MAXD: begin
        if (joint_q == LastJoint) begin
          joint_d = '0;
          state_d = ST_MUL_T;
        end else begin
          joint_d = joint_q + 1'b1;
        end
      end
      ST_MUL_T:  state_d = status_i.maxd_zero ? ST_IDLE : ST_GO_T;
      ST_GO_T:   state_d = ST_WAIT_T;
      ST_WAIT_T: if (status_i.div_done) state_d = ST_GO_C;
      ST_GO_C:   state_d = ST_WAIT_C;
      ST_WAIT_C: if (status_i.div_done) state_d = ST_MUL_S;
      ST_MUL_S:  state_d = status_i.count_zero ? ST_IDLE : ST_GO_S;
      ST_GO_S:   state_d = ST_WAIT_S;
      ST_WAIT_S: begin
        if (status_i.div_done) begin
          if (joint_q == LastJoint) begin
            joint_d = '0;
            state_d = ST_EMIT;
          end else begin
            joint_d = joint_q + 1'b1;
            state_d = ST_MUL_S;
          end
        end
      end
      ST_EMIT:   if (status_i.out_free && status_i.last) state_d = ST_IDLE;
      ST_SINGLE: if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.joint   = joint_q;
    cmd_o.div_sel = DIV_STEP;
    in_stall_o    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:   cmd_o.capture = in_valid_i;
      ST_MAXD:   cmd_o.maxd_step = 1'b1;
      ST_MUL_T:  cmd_o.mul_t = 1'b1;
      ST_GO_T: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_TIME;
      end
      ST_WAIT_T: cmd_o.div_sel = DIV_TIME;
      ST_GO_C: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_COUNT;
      end
      ST_WAIT_C: cmd_o.div_sel = DIV_COUNT;
      ST_MUL_S:  cmd_o.mul_s = 1'b1;
      ST_GO_S:   cmd_o.div_go = 1'b1;
      ST_WAIT_S: cmd_o.div_sel = DIV_STEP;
      ST_EMIT:   cmd_o.emit = status_i.out_free;
      ST_SINGLE: cmd_o.load_single = status_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/joint_space_linear_interpolator.sv
// ----------------------------------------------------------------------------
// joint_space_linear_interpolator
// Six-joint linear interpolator from a start pose to an end pose.
// ----------------------------------------------------------------------------
// Input channel: a start pose and an end pose (in_valid_i / in_stall_o).
// Output channel: frames of six angles, frame time and last flag
// (out_valid_o / out_stall_i). Registers are written through cfg_*; the user
// must write them only while idle, as the block itself does not enforce it.
// Single mode: the captured end pose is loaded into the output register once
// it is free, as one frame. Multi-frame mode: a sweep of the joint deltas,
// two divisions for the move time and the frame count, then six step
// divisions; then one frame per cycle while the receiver does not stall, up
// to MaxFrames frames. The serial divider sets the setup time. A move with
// no motion or shorter than one period gives no frames.
// The next pose pair is taken once the last frame sits in the output register.
// A stalled receiver holds the output register and the frame sequence.
// Reset clears the sequencer, the output valid and loads the register
// defaults (mode 0, speed 640, period 10, transition time 1000).
// ----------------------------------------------------------------------------
`default_nettype none

module joint_space_linear_interpolator
  import jsli_pkg::*;
#(
  parameter int unsigned MaxFrames = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CfgW-1:0]   cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [AngleW-1:0] start_angle_0_i,
  input  wire logic [AngleW-1:0] start_angle_1_i,
  input  wire logic [AngleW-1:0] start_angle_2_i,
  input  wire logic [AngleW-1:0] start_angle_3_i,
  input  wire logic [AngleW-1:0] start_angle_4_i,
  input  wire logic [AngleW-1:0] start_angle_5_i,
  input  wire logic [AngleW-1:0] end_angle_0_i,
  input  wire logic [AngleW-1:0] end_angle_1_i,
  input  wire logic [AngleW-1:0] end_angle_2_i,
  input  wire logic [AngleW-1:0] end_angle_3_i,
  input  wire logic [AngleW-1:0] end_angle_4_i,
  input  wire logic [AngleW-1:0] end_angle_5_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [AngleW-1:0]      joint_angle_0_o,
  output logic [AngleW-1:0]      joint_angle_1_o,
  output logic [AngleW-1:0]      joint_angle_2_o,
  output logic [AngleW-1:0]      joint_angle_3_o,
  output logic [AngleW-1:0]      joint_angle_4_o,
  output logic [AngleW-1:0]      joint_angle_5_o,
  output logic [CfgW-1:0]        frame_time_o,
  output logic                   last_frame_o
);

  localparam int unsigned FrmW = $clog2(MaxFrames + 1);

  logic            mode_q;
  logic [CfgW-1:0] speed_q, period_q, ttime_q;
  cmd_t            cmd;
  status_t         status;
  logic [NumJoints-1:0][AngleW-1:0] start_v, end_v, angle_v;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      speed_q  <= CfgW'(640);
      period_q <= CfgW'(10);
      ttime_q  <= CfgW'(1000);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODE:   mode_q   <= cfg_data_i[0];
        REG_SPEED:  speed_q  <= cfg_data_i;
        REG_PERIOD: period_q <= cfg_data_i;
        REG_TTIME:  ttime_q  <= cfg_data_i;
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  assign start_v = {start_angle_5_i, start_angle_4_i, start_angle_3_i,
                    start_angle_2_i, start_angle_1_i, start_angle_0_i};
  assign end_v   = {end_angle_5_i, end_angle_4_i, end_angle_3_i,
                    end_angle_2_i, end_angle_1_i, end_angle_0_i};

  jsli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .multi_i    (mode_q),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jsli_datapath #(
    .MaxFrames (MaxFrames),
    .FrmW      (FrmW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .speed_i      (speed_q),
    .period_i     (period_q),
    .ttime_i      (ttime_q),
    .start_i      (start_v),
    .end_i        (end_v),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .angle_o      (angle_v),
    .frame_time_o (frame_time_o),
    .last_o       (last_frame_o)
  );

  assign joint_angle_0_o = angle_v[0];
  assign joint_angle_1_o = angle_v[1];
  assign joint_angle_2_o = angle_v[2];
  assign joint_angle_3_o = angle_v[3];
  assign joint_angle_4_o = angle_v[4];
  assign joint_angle_5_o = angle_v[5];

endmodule

`default_nettype wire
